@@ hw/rtl/blsl_pkg.sv @@
`default_nettype none

package blsl_pkg;

   // Width of the image length limit register and of the word counter.
   localparam int unsigned COUNT_W = 21;

   // Upper bound on the image length, whatever the register holds.
   localparam logic [COUNT_W-1:0] IMAGE_WORDS_MAX = COUNT_W'(131072);
   localparam logic [COUNT_W-1:0] MAX_WORDS_RESET = COUNT_W'(131072);

   // Header word fields.
   localparam int unsigned BYTE_BITS        = 8;
   localparam logic [7:0]  SIG_FIRST        = 8'h43;
   localparam logic [7:0]  SIG_SECOND       = 8'h59;
   localparam int unsigned CTL_NOEXEC_BIT   = 0;
   localparam logic [7:0]  TYPE_CHECKSUMMED = 8'hB0;

   // Depth of the queue between the parser and the result port.
   localparam int unsigned QUEUE_DEPTH   = 4;
   localparam int unsigned QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_COUNT_W = QUEUE_PTR_W + 1;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_JUMP  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_SIG   = 3'd1,
      ST_NOT_EXEC  = 3'd2,
      ST_BAD_TYPE  = 3'd3,
      ST_CHECKSUM  = 3'd4,
      ST_TOO_LONG  = 3'd5,
      ST_TRUNCATED = 3'd6
   } status_type;

   typedef enum logic [6:0] {
      PH_HEADER     = 7'b0000001,
      PH_LENGTH     = 7'b0000010,
      PH_SECT_ADDR  = 7'b0000100,
      PH_DATA       = 7'b0001000,
      PH_ENTRY_ADDR = 7'b0010000,
      PH_CHECKSUM   = 7'b0100000,
      PH_FINISHED   = 7'b1000000
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] target_address;
      logic [31:0] write_data;
      status_type  status;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type item;
   } push_type;

endpackage

`default_nettype wire

@@ hw/rtl/blsl_front.sv @@
`default_nettype none

// Image parser: classifies one word per accepted beat and emits at most
// one result into the queue.
module blsl_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [31:0]                   word,
   input  wire logic                          last,
   input  wire logic                          csr_wr_en,
   input  wire logic [blsl_pkg::COUNT_W-1:0]  csr_wr_data,
   output blsl_pkg::push_type                 push
);

   blsl_pkg::phase_type phase_ff, phase_in;
   logic [blsl_pkg::COUNT_W-1:0] words_seen_ff, words_seen_in;
   logic [blsl_pkg::COUNT_W-1:0] max_words_ff, max_words_in;
   logic [31:0] words_left_ff, words_left_in;
   logic [31:0] write_address_ff, write_address_in;
   logic [31:0] running_sum_ff, running_sum_in;
   logic [31:0] entry_address_ff, entry_address_in;

   logic [blsl_pkg::COUNT_W-1:0] limit;
   logic [7:0] b0, b1, b2, b3;
   logic       finished_now;
   logic [31:0] left_dec;

   assign limit = (max_words_ff < blsl_pkg::IMAGE_WORDS_MAX) ? max_words_ff
                                                              : blsl_pkg::IMAGE_WORDS_MAX;
   assign b0 = word[0*blsl_pkg::BYTE_BITS +: blsl_pkg::BYTE_BITS];
   assign b1 = word[1*blsl_pkg::BYTE_BITS +: blsl_pkg::BYTE_BITS];
   assign b2 = word[2*blsl_pkg::BYTE_BITS +: blsl_pkg::BYTE_BITS];
   assign b3 = word[3*blsl_pkg::BYTE_BITS +: blsl_pkg::BYTE_BITS];
   assign left_dec = words_left_ff - 32'd1;
   assign max_words_in = csr_wr_en ? csr_wr_data : max_words_ff;

   always_comb begin
      phase_in         = phase_ff;
      words_seen_in    = words_seen_ff;
      words_left_in    = words_left_ff;
      write_address_in = write_address_ff;
      running_sum_in   = running_sum_ff;
      entry_address_in = entry_address_ff;
      finished_now     = 1'b0;
      push.valid       = 1'b0;
      push.item        = '{blsl_pkg::KIND_ERROR, 32'd0, 32'd0, blsl_pkg::ST_OK};

      if (accept) begin
         if (phase_ff == blsl_pkg::PH_FINISHED) begin
            finished_now = 1'b1;
         end else if (words_seen_ff >= limit) begin
            push.valid       = 1'b1;
            push.item.status = blsl_pkg::ST_TOO_LONG;
            finished_now     = 1'b1;
         end else begin
            words_seen_in = words_seen_ff + blsl_pkg::COUNT_W'(1);
            case (phase_ff)
               blsl_pkg::PH_HEADER: begin
                  if (b0 != blsl_pkg::SIG_FIRST || b1 != blsl_pkg::SIG_SECOND) begin
                     push.valid       = 1'b1;
                     push.item.status = blsl_pkg::ST_BAD_SIG;
                     finished_now     = 1'b1;
                  end else if (b2[blsl_pkg::CTL_NOEXEC_BIT]) begin
                     push.valid       = 1'b1;
                     push.item.status = blsl_pkg::ST_NOT_EXEC;
                     finished_now     = 1'b1;
                  end else if (b3 != blsl_pkg::TYPE_CHECKSUMMED) begin
                     push.valid       = 1'b1;
                     push.item.status = blsl_pkg::ST_BAD_TYPE;
                     finished_now     = 1'b1;
                  end else begin
                     running_sum_in = 32'd0;
                     phase_in       = blsl_pkg::PH_LENGTH;
                  end
               end
               blsl_pkg::PH_LENGTH: begin
                  words_left_in = word;
                  phase_in = (word == 32'd0) ? blsl_pkg::PH_ENTRY_ADDR
                                             : blsl_pkg::PH_SECT_ADDR;
               end
               blsl_pkg::PH_SECT_ADDR: begin
                  write_address_in = word;
                  phase_in         = blsl_pkg::PH_DATA;
               end
               blsl_pkg::PH_DATA: begin
                  push.valid     = 1'b1;
                  push.item      = '{blsl_pkg::KIND_WRITE, write_address_ff, word,
                                     blsl_pkg::ST_OK};
                  running_sum_in   = running_sum_ff + word;
                  write_address_in = write_address_ff + 32'd4;
                  words_left_in    = left_dec;
                  if (left_dec == 32'd0) begin
                     phase_in = blsl_pkg::PH_LENGTH;
                  end
               end
               blsl_pkg::PH_ENTRY_ADDR: begin
                  entry_address_in = word;
                  phase_in         = blsl_pkg::PH_CHECKSUM;
               end
               blsl_pkg::PH_CHECKSUM: begin
                  push.valid   = 1'b1;
                  finished_now = 1'b1;
                  if (word == running_sum_ff) begin
                     push.item = '{blsl_pkg::KIND_JUMP, entry_address_ff, 32'd0,
                                   blsl_pkg::ST_OK};
                  end else begin
                     push.item.status = blsl_pkg::ST_CHECKSUM;
                  end
               end
               default: begin
                  phase_in = blsl_pkg::PH_HEADER;
               end
            endcase
         end

         if (finished_now) begin
            phase_in = blsl_pkg::PH_FINISHED;
         end

         if (last) begin
            // A final word that does not close the image reports truncation.
            if (!finished_now) begin
               push.valid = 1'b1;
               push.item  = '{blsl_pkg::KIND_ERROR, 32'd0, 32'd0, blsl_pkg::ST_TRUNCATED};
            end
            phase_in         = blsl_pkg::PH_HEADER;
            words_seen_in    = '0;
            words_left_in    = 32'd0;
            write_address_in = 32'd0;
            running_sum_in   = 32'd0;
            entry_address_in = 32'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= blsl_pkg::PH_HEADER;
         words_seen_ff    <= '0;
         words_left_ff    <= 32'd0;
         write_address_ff <= 32'd0;
         running_sum_ff   <= 32'd0;
         entry_address_ff <= 32'd0;
         max_words_ff     <= blsl_pkg::MAX_WORDS_RESET;
      end else begin
         phase_ff         <= phase_in;
         words_seen_ff    <= words_seen_in;
         words_left_ff    <= words_left_in;
         write_address_ff <= write_address_in;
         running_sum_ff   <= running_sum_in;
         entry_address_ff <= entry_address_in;
         max_words_ff     <= max_words_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/blsl_queue.sv @@
`default_nettype none

// Result queue between the parser and the result port.
module blsl_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire blsl_pkg::push_type   push,
   output logic                      full,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output blsl_pkg::result_type      out_item
);

   blsl_pkg::result_type slots_ff [blsl_pkg::QUEUE_DEPTH];
   logic [blsl_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [blsl_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [blsl_pkg::QUEUE_COUNT_W-1:0] count_ff, count_in;
   logic pop;

   assign full      = (count_ff == blsl_pkg::QUEUE_COUNT_W'(blsl_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = slots_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + blsl_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + blsl_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + blsl_pkg::QUEUE_COUNT_W'(1);
      end else if (pop && !push.valid) begin
         count_in = count_ff - blsl_pkg::QUEUE_COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slots_ff[wr_ptr_ff] <= push.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/boot_image_section_loader.sv @@
// Boot image section loader.
// Image words enter on the req_ stream, one 32-bit little-endian word per
// beat, with req_tlast on the final word of an image. The parser checks the
// header, walks the length/address/data sections and keeps a running sum.
// Each data word leaves on the rsp_ stream as a memory write beat; the
// closing checksum word yields a jump beat or an error beat, and any
// failure (bad header, checksum, image too long, truncation) yields one
// error beat. Words after a jump or error are dropped until req_tlast.
// Each result is registered in the result queue and shows on rsp_ behind any
// results already waiting there. Throughput is one word per cycle while the
// result queue is not full.
// The csr_ port sets the image length limit; write it only while idle.
// Reset clears the parser and the result queue and sets the limit to
// 131072 words. When the receiver stalls, results collect in a four-entry
// queue; once it is full, req_tready drops until a beat leaves.
`default_nettype none

module boot_image_section_loader (
   input  wire logic        clock,
   input  wire logic        reset,
   // Image input stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] image_word
   input  wire logic        req_tlast,   // last_word
   // Result stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // [31:0] target_address, [63:32] write_data,
                                         // [66:64] status, [71:67] zero
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   // Configuration: image length limit in words.
   input  wire logic        csr_wr_en,
   input  wire logic [20:0] csr_wr_data
);

   logic                 accept;
   logic                 queue_full;
   blsl_pkg::push_type   push;
   blsl_pkg::result_type head;

   // The front side only waits for queue space, never on rsp_tready directly.
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   blsl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .word        (req_tdata),
      .last        (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push)
   );

   blsl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (queue_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head)
   );

   assign rsp_tdata = {5'd0, head.status, head.write_data, head.target_address};
   assign rsp_tuser = head.kind;

   // A result is only produced for an accepted word.
   a_push_needs_accept : assert property (@(posedge clock) disable iff (reset)
      push.valid |-> accept)
      else $error("result pushed without an accepted word");

   // Writes and jumps always report ok.
   a_ok_status : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (head.kind == blsl_pkg::KIND_WRITE || head.kind == blsl_pkg::KIND_JUMP)
      |-> head.status == blsl_pkg::ST_OK)
      else $error("write or jump beat with error status");

   // Error beats carry zero address and data and a nonzero status.
   a_error_shape : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && head.kind == blsl_pkg::KIND_ERROR
      |-> head.target_address == 32'd0 && head.write_data == 32'd0
          && head.status != blsl_pkg::ST_OK)
      else $error("malformed error beat");

   // Nothing is pushed into a full queue.
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !push.valid)
      else $error("push into full result queue");

endmodule

`default_nettype wire
